@@ hw/rtl/hdbc_pkg.sv @@
// Package for the per-channel hit deduplication unit.
// Holds geometry constants, payload structs, the state encoding and a bit-search helper.
// Has no dependencies.
package hdbc_pkg;

	// Detector geometry.
	localparam int LAYERS   = 4;
	localparam int CHIPS    = 26;
	localparam int CHANNELS = 128;

	// Number of layer module registers on the configuration port.
	localparam int NREG      = 4;
	localparam int CFG_IDX_W = 2;
	localparam int MODULE_W  = 4;

	// Entry address is the concatenation {layer, chip - 1, channel}, which keeps the
	// layer, chip, channel order while avoiding any multiply or divide.
	localparam int LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int CHIP_W  = (CHIPS > 1) ? $clog2(CHIPS) : 1;
	localparam int CHAN_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W  = LAYER_W + CHIP_W + CHAN_W;
	localparam int ENTRIES = 2 ** ADDR_W;

	// Occupancy memory holds one row of sixteen entries per word.
	localparam int ROW_SEL_W = 4;
	localparam int ROW_BITS  = 2 ** ROW_SEL_W;
	localparam int ROW_W     = ADDR_W - ROW_SEL_W;
	localparam int ROWS      = 2 ** ROW_W;

	// Item modes.
	localparam logic MODE_STORE = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// One input item.
	typedef struct packed {
		logic        mode;
		logic [3:0]  hit_module;
		logic [4:0]  hit_chip;
		logic [6:0]  hit_channel;
		logic [2:0]  hit_adc;
		logic [7:0]  hit_ampl;
		logic [3:0]  hit_fpga;
		logic [3:0]  hit_fem;
		logic [6:0]  hit_bco;
		logic [15:0] hit_bco_full;
		logic [23:0] hit_event;
	} hit_in_t;

	// One result item.
	typedef struct packed {
		logic        found;
		logic [3:0]  out_module;
		logic [4:0]  out_chip;
		logic [6:0]  out_channel;
		logic [2:0]  out_adc;
		logic [7:0]  out_ampl;
		logic [3:0]  out_fpga;
		logic [3:0]  out_fem;
		logic [6:0]  out_bco;
		logic [15:0] out_bco_full;
		logic [23:0] out_event;
	} hit_out_t;

	// What is kept per entry in the payload memory.
	typedef struct packed {
		logic [3:0]  module_id;
		logic [2:0]  adc;
		logic [7:0]  ampl;
		logic [3:0]  fpga;
		logic [3:0]  fem;
		logic [6:0]  bco;
		logic [15:0] full_bco;
		logic [23:0] evt;
	} stored_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STORE,
		ST_SCAN,
		ST_FETCH,
		ST_EMIT
	} state_t;

	// Position of the lowest set bit of an occupancy row.
	function automatic logic [ROW_SEL_W-1:0] lowest_bit(input logic [ROW_BITS-1:0] v);
		logic [ROW_SEL_W-1:0] pos;
		pos = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				pos = ROW_SEL_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

@@ hw/rtl/hit_dedup_by_channel_unit.sv @@
// Top level of the per-channel hit deduplication unit.
// Contains the occupancy and payload memories, the sequencer and the output register.
// Depends on hdbc_pkg.

// Stores hits by (layer, chip, channel), keeping only the last hit per channel, and
// drains the kept hits in layer, chip, channel order. After reset the unit clears its
// occupancy memory row by row and holds item_stall high meanwhile; configuration
// writes are taken during that time. A kept store reads and writes back a 16-entry
// occupancy row; an ignored store writes neither memory and the unit stays idle.
// A drain item walks the occupancy memory at one row of 16 entries per cycle from
// the drain cursor on, until it finds a kept entry or, for a drain that finds the
// event empty, until it has passed the last row. A drain also waits while the
// previous result still sits in the output register under stall. The next item is
// taken while an earlier result still waits in the output register.
module hit_dedup_by_channel_unit
	import hdbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 item_valid,
	output logic                 item_stall,
	input  hit_in_t              item,

	output logic                 result_valid,
	input  logic                 result_stall,
	output hit_out_t             result,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MODULE_W-1:0]  cfg_data
);

	// Memories.
	logic [ROW_BITS-1:0] occ_mem [ROWS];
	stored_t             pay_mem [ENTRIES];

	state_t              state_q, state_d;
	logic [MODULE_W-1:0] layer_reg_q [NREG];
	logic [ADDR_W:0]     cursor_q;
	logic [ROW_W-1:0]    clr_q;
	logic [ROW_W-1:0]    scan_row_q;
	logic [ROW_W-1:0]    eval_row_s1;
	logic                rd_valid_s1;
	logic [ROW_W-1:0]    st_row_s1;
	logic [ROW_SEL_W-1:0] st_bit_s1;
	logic [ADDR_W-1:0]   hit_addr_q;
	hit_out_t            res_q;
	hit_out_t            result_q;
	logic                result_valid_q;

	logic [ROW_BITS-1:0] occ_rdata_s1;
	stored_t             pay_rdata_s1;

	// Combinational control.
	logic                accept;
	logic                lay_match;
	logic [LAYER_W-1:0]  lay_idx;
	logic                range_ok;
	logic [4:0]          chip_m1;
	logic [ADDR_W-1:0]   st_addr;
	logic                store_ok;
	logic                occ_we;
	logic [ROW_W-1:0]    occ_waddr;
	logic [ROW_BITS-1:0] occ_wdata;
	logic [ROW_W-1:0]    occ_raddr;
	logic                pay_we;
	logic [ROW_SEL_W-1:0] scan_bit;
	logic                scan_hit;
	logic                scan_end;
	logic                slot_free;
	stored_t             st_word;

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign accept       = item_valid && !item_stall;
	assign slot_free    = !result_valid_q || !result_stall;

	// Map the module to a layer; the lowest matching layer wins.
	always_comb begin
		lay_match = 1'b0;
		lay_idx   = '0;
		for (int l = NREG - 1; l >= 0; l--) begin
			if (l < LAYERS && layer_reg_q[l] == item.hit_module) begin
				lay_match = 1'b1;
				lay_idx   = LAYER_W'(l);
			end
		end
	end

	// Entry address and the checks that decide whether a store is kept. A store behind
	// the drain cursor would be discarded at the end of the drain, so it is not marked.
	assign range_ok = (item.hit_chip != 5'd0) && (int'(item.hit_chip) <= CHIPS)
		&& (int'(item.hit_channel) < CHANNELS);
	assign chip_m1  = item.hit_chip - 5'd1;
	assign st_addr  = {lay_idx, CHIP_W'(chip_m1), CHAN_W'(item.hit_channel)};
	assign store_ok = lay_match && range_ok && ({1'b0, st_addr} >= cursor_q);

	assign st_word = '{
		module_id: item.hit_module,
		adc:       item.hit_adc,
		ampl:      item.hit_ampl,
		fpga:      item.hit_fpga,
		fem:       item.hit_fem,
		bco:       item.hit_bco,
		full_bco:  item.hit_bco_full,
		evt:       item.hit_event
	};

	// Scan evaluation of the row that was read in the previous cycle.
	assign scan_bit = lowest_bit(occ_rdata_s1);
	assign scan_hit = (state_q == ST_SCAN) && rd_valid_s1 && (occ_rdata_s1 != '0);
	assign scan_end = (state_q == ST_SCAN) && rd_valid_s1 && (occ_rdata_s1 == '0)
		&& (eval_row_s1 == '1);

	// Next state and memory port control.
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		occ_we     = 1'b0;
		occ_waddr  = clr_q;
		occ_wdata  = '0;
		occ_raddr  = scan_row_q;
		pay_we     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				occ_we = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				occ_raddr  = st_addr[ADDR_W-1:ROW_SEL_W];
				if (item_valid) begin
					if (item.mode == MODE_DRAIN) begin
						state_d = cursor_q[ADDR_W] ? ST_EMIT : ST_SCAN;
					end else if (store_ok) begin
						pay_we  = 1'b1;
						state_d = ST_STORE;
					end
				end
			end
			ST_STORE: begin
				occ_we    = 1'b1;
				occ_waddr = st_row_s1;
				occ_wdata = occ_rdata_s1 | (ROW_BITS'(1) << st_bit_s1);
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_hit) begin
					occ_we    = 1'b1;
					occ_waddr = eval_row_s1;
					occ_wdata = occ_rdata_s1 & ~(ROW_BITS'(1) << scan_bit);
					state_d   = ST_FETCH;
				end else if (scan_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_FETCH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Occupancy memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_waddr] <= occ_wdata;
		end
		occ_rdata_s1 <= occ_mem[occ_raddr];
	end

	// Payload memory: written on a kept store, read at the entry the scan found.
	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[st_addr] <= st_word;
		end
		pay_rdata_s1 <= pay_mem[{eval_row_s1, scan_bit}];
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Layer module registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_reg_q[0] <= 4'd6;
			layer_reg_q[1] <= 4'd5;
			layer_reg_q[2] <= 4'd8;
			layer_reg_q[3] <= 4'd2;
		end else if (cfg_valid && cfg_ready) begin
			layer_reg_q[cfg_index] <= cfg_data;
		end
	end

	// Control counters: clearing pass, scan pipeline valid and drain cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			cursor_q    <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ROW_W'(1);
			end
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_EMIT && slot_free) begin
				cursor_q <= res_q.found ? ({1'b0, hit_addr_q} + (ADDR_W + 1)'(1)) : '0;
			end
		end
	end

	// Scan addressing and store row capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			st_row_s1  <= st_addr[ADDR_W-1:ROW_SEL_W];
			st_bit_s1  <= st_addr[ROW_SEL_W-1:0];
			scan_row_q <= cursor_q[ADDR_W-1:ROW_SEL_W];
		end else if (state_q == ST_SCAN) begin
			scan_row_q <= scan_row_q + ROW_W'(1);
		end
		eval_row_s1 <= scan_row_q;
		if (scan_hit) begin
			hit_addr_q <= {eval_row_s1, scan_bit};
		end
	end

	// Result assembly: empty when the event is drained, else the fetched entry.
	always_ff @(posedge clk) begin
		if ((accept && item.mode == MODE_DRAIN) || scan_end) begin
			res_q <= '0;
		end else if (state_q == ST_FETCH) begin
			res_q.found        <= 1'b1;
			res_q.out_module   <= pay_rdata_s1.module_id;
			res_q.out_chip     <= 5'(hit_addr_q[CHAN_W +: CHIP_W]) + 5'd1;
			res_q.out_channel  <= 7'(hit_addr_q[CHAN_W-1:0]);
			res_q.out_adc      <= pay_rdata_s1.adc;
			res_q.out_ampl     <= pay_rdata_s1.ampl;
			res_q.out_fpga     <= pay_rdata_s1.fpga;
			res_q.out_fem      <= pay_rdata_s1.fem;
			res_q.out_bco      <= pay_rdata_s1.bco;
			res_q.out_bco_full <= pay_rdata_s1.full_bco;
			res_q.out_event    <= pay_rdata_s1.evt;
		end
	end

	// Output register: loaded when the slot is free, emptied on a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			result_valid_q <= 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			result_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	// A cursor past the last entry always sits exactly at the end.
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q[ADDR_W] |-> (cursor_q[ADDR_W-1:0] == '0))
		else $error("drain cursor beyond end of the entry space");

	// A new result only appears after the emit state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("result loaded outside the emit state");

	// Draining an entry clears exactly one occupancy bit.
	a_one_bit_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		scan_hit |-> ($countones(occ_wdata) == $countones(occ_rdata_s1) - 1))
		else $error("scan write-back cleared the wrong number of bits");

	// An empty drain result rewinds the cursor.
	a_drain_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && slot_free && !res_q.found) |=> (cursor_q == '0))
		else $error("cursor not rewound after the event was drained");
`endif

endmodule
